### rtl/sspf_pkg.sv
// ----------------------------------------------------------------------------
// sspf_pkg
// Shared types and constants of the sensor sample packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package sspf_pkg;

    localparam int NUM_VALUES = 6;
    localparam int VALUE_W    = 12;
    localparam int ROW_W      = NUM_VALUES * VALUE_W;
    localparam int SPP_W      = 5;
    localparam int KIND_W     = 2;

    localparam logic [SPP_W-1:0] SPP_RESET = 5'd20;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAILER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_RECORD,
        ST_TRAILER
    } sspf_state_t;

    typedef struct packed {
        logic push;
        logic clear;
        logic load_hdr;
        logic load_rec;
        logic load_trl;
    } sspf_cmd_t;

    typedef struct packed {
        logic send_ok;
        logic out_free;
        logic last_rec;
    } sspf_status_t;

endpackage

`default_nettype wire

### rtl/sspf_ctrl.sv
// ----------------------------------------------------------------------------
// sspf_ctrl
// Packet sequencer: takes requests and steps through header, records, trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module sspf_ctrl
    import sspf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         func,
    output logic              in_stall,
    output sspf_cmd_t         cmd,
    input  wire sspf_status_t status
);

    sspf_state_t state_reg;
    sspf_state_t state_next;
    logic        accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !func && status.send_ok)
                begin
                    state_next = ST_HEADER;
                end
            end
            ST_HEADER:
            begin
                if (status.out_free)
                begin
                    state_next = ST_RECORD;
                end
            end
            ST_RECORD:
            begin
                if (status.out_free && status.last_rec)
                begin
                    state_next = ST_TRAILER;
                end
            end
            ST_TRAILER:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.push  = accept && !func;
                cmd.clear = accept && func;
            end
            ST_HEADER:
            begin
                cmd.load_hdr = status.out_free;
            end
            ST_RECORD:
            begin
                cmd.load_rec = status.out_free;
            end
            ST_TRAILER:
            begin
                cmd.load_trl = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sspf_datapath.sv
// ----------------------------------------------------------------------------
// sspf_datapath
// Sample queue memory, pointers, record packing, checksum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sspf_datapath
    import sspf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_RECORDS = 25
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sspf_cmd_t          cmd,
    output sspf_status_t            status,
    input  wire logic [VALUE_W-1:0] value_a,
    input  wire logic [VALUE_W-1:0] value_b,
    input  wire logic [VALUE_W-1:0] value_c,
    input  wire logic [VALUE_W-1:0] value_d,
    input  wire logic [VALUE_W-1:0] value_e,
    input  wire logic [VALUE_W-1:0] value_f,
    input  wire logic               link_ready,
    input  wire logic               cfg_write_en,
    input  wire logic [SPP_W-1:0]   cfg_write_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [KIND_W-1:0]       kind,
    output logic [7:0]              sequence_res,
    output logic [4:0]              record_count,
    output logic [63:0]             packed_front,
    output logic [7:0]              packed_tail,
    output logic [7:0]              sum_byte,
    output logic                    final_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(QUEUE_DEPTH);
    localparam logic [OCC_W-1:0] OCC_RECS  = OCC_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic [ROW_W-1:0] store_mem [QUEUE_DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] head_reg, head_next, head_inc;
    logic [PTR_W-1:0] tail_reg, tail_next, tail_inc;
    logic [OCC_W-1:0] occ_reg, occ_next, occ_after;
    logic [CNT_W-1:0] count_reg, count_next, count_calc;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [7:0]       pkt_reg, pkt_next;
    logic [7:0]       sum_reg, sum_next;
    logic [SPP_W-1:0] spp_reg;
    logic             not_full;
    logic             out_valid_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [7:0]        seq_reg;
    logic [4:0]        rcnt_reg;
    logic [63:0]       front_reg;
    logic [7:0]        tailb_reg;
    logic [7:0]        sumb_reg;
    logic              final_reg;

    logic [7:0] rec_bytes [9];
    logic [7:0] rec_sum;
    logic [VALUE_W-1:0] va, vb;

    // queue bookkeeping
    assign not_full  = occ_reg < OCC_FULL;
    assign head_inc  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign occ_after = not_full ? occ_reg + 1'b1 : occ_reg;

    always_comb
    begin
        if (occ_after > OCC_RECS)
        begin
            count_calc = CNT_MAX;
        end
        else
        begin
            count_calc = CNT_W'(occ_after);
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        pkt_next    = pkt_reg;
        sum_next    = sum_reg;
        if (cmd.clear)
        begin
            head_next = '0;
            tail_next = '0;
            occ_next  = '0;
        end
        if (cmd.push)
        begin
            tail_next  = not_full ? tail_inc : tail_reg;
            occ_next   = occ_after;
            count_next = count_calc;
        end
        if (cmd.load_hdr)
        begin
            remain_next = count_reg;
            sum_next    = pkt_reg + 8'(count_reg);
            pkt_next    = pkt_reg + 8'd1;
        end
        if (cmd.load_rec)
        begin
            head_next   = head_inc;
            occ_next    = occ_reg - 1'b1;
            remain_next = remain_reg - 1'b1;
            sum_next    = rec_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            count_reg  <= '0;
            remain_reg <= '0;
            pkt_reg    <= '0;
            sum_reg    <= '0;
            spp_reg    <= SPP_RESET;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            pkt_reg    <= pkt_next;
            sum_reg    <= sum_next;
            if (cfg_write_en)
            begin
                spp_reg <= cfg_write_data;
            end
        end
    end

    // sample store, read continuously at the next head slot
    always_ff @(posedge clk)
    begin
        if (cmd.push && not_full)
        begin
            store_mem[tail_reg] <= {value_f, value_e, value_d, value_c, value_b, value_a};
        end
        rd_data_reg <= store_mem[head_next];
    end

    // record packing and checksum
    always_comb
    begin
        va = '0;
        vb = '0;
        for (int j = 0; j < 3; j++)
        begin
            va = rd_data_reg[(2 * j) * VALUE_W +: VALUE_W];
            vb = rd_data_reg[(2 * j + 1) * VALUE_W +: VALUE_W];
            rec_bytes[3 * j]     = {va[11:8], vb[11:8]};
            rec_bytes[3 * j + 1] = va[7:0];
            rec_bytes[3 * j + 2] = vb[7:0];
        end
    end

    always_comb
    begin
        rec_sum = sum_reg;
        for (int j = 0; j < 9; j++)
        begin
            rec_sum = rec_sum + rec_bytes[j];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_hdr || cmd.load_rec || cmd.load_trl)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_hdr)
        begin
            kind_reg  <= KIND_HEADER;
            seq_reg   <= pkt_reg;
            rcnt_reg  <= 5'(count_reg);
            front_reg <= '0;
            tailb_reg <= '0;
            sumb_reg  <= '0;
            final_reg <= 1'b0;
        end
        else if (cmd.load_rec)
        begin
            kind_reg  <= KIND_RECORD;
            seq_reg   <= '0;
            rcnt_reg  <= '0;
            front_reg <= {rec_bytes[0], rec_bytes[1], rec_bytes[2], rec_bytes[3],
                          rec_bytes[4], rec_bytes[5], rec_bytes[6], rec_bytes[7]};
            tailb_reg <= rec_bytes[8];
            sumb_reg  <= '0;
            final_reg <= 1'b0;
        end
        else if (cmd.load_trl)
        begin
            kind_reg  <= KIND_TRAILER;
            seq_reg   <= '0;
            rcnt_reg  <= '0;
            front_reg <= '0;
            tailb_reg <= '0;
            sumb_reg  <= sum_reg;
            final_reg <= 1'b1;
        end
    end

    assign status.send_ok  = link_ready && (occ_after >= OCC_W'(spp_reg));
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.last_rec = remain_reg == CNT_ONE;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign sequence_res = seq_reg;
    assign record_count = rcnt_reg;
    assign packed_front = front_reg;
    assign packed_tail  = tailb_reg;
    assign sum_byte     = sumb_reg;
    assign final_res    = final_reg;

endmodule

`default_nettype wire

### rtl/sensor_sample_packet_framer.sv
// ----------------------------------------------------------------------------
// sensor_sample_packet_framer
// Queues six-channel sensor samplings and frames them into checksummed packets.
// ----------------------------------------------------------------------------
// Each request pushes one sampling (func low) or clears the queue (func high).
// When a push finds link_ready high and at least samples_per_packet samplings
// queued, the block emits a header, one result per record (up to MAX_RECORDS,
// oldest first) and a trailer carrying the mod-256 byte sum; in_stall stays
// high meanwhile. Results go out one per cycle while out_stall is low, read
// from the sample store's read port into the output register. Samplings
// pushed into a full queue are dropped; the packet counter survives a clear.
`default_nettype none

module sensor_sample_packet_framer
    import sspf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_RECORDS = 25
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [VALUE_W-1:0] value_a,
    input  wire logic [VALUE_W-1:0] value_b,
    input  wire logic [VALUE_W-1:0] value_c,
    input  wire logic [VALUE_W-1:0] value_d,
    input  wire logic [VALUE_W-1:0] value_e,
    input  wire logic [VALUE_W-1:0] value_f,
    input  wire logic               link_ready,
    input  wire logic               cfg_write_en,
    input  wire logic [SPP_W-1:0]   cfg_write_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [KIND_W-1:0]       kind,
    output logic [7:0]              sequence_res,
    output logic [4:0]              record_count,
    output logic [63:0]             packed_front,
    output logic [7:0]              packed_tail,
    output logic [7:0]              sum_byte,
    output logic                    final_res
);

    sspf_cmd_t    cmd;
    sspf_status_t status;

    sspf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    sspf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .value_a        (value_a),
        .value_b        (value_b),
        .value_c        (value_c),
        .value_d        (value_d),
        .value_e        (value_e),
        .value_f        (value_f),
        .link_ready     (link_ready),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .sequence_res   (sequence_res),
        .record_count   (record_count),
        .packed_front   (packed_front),
        .packed_tail    (packed_tail),
        .sum_byte       (sum_byte),
        .final_res      (final_res)
    );

    // a clear emits nothing and leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func) |=> !in_stall)
        else $error("block busy after clear request");

    // a trailer is followed by a header, never directly by a record or trailer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && final_res) |=> (!out_valid || kind == KIND_HEADER))
        else $error("result after trailer is not a header");

    // requests are held off while a packet is still being framed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && kind == KIND_HEADER) |=> in_stall)
        else $error("request accepted in the middle of a packet");

endmodule

`default_nettype wire

### bench/sensor_sample_packet_framer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_sample_packet_framer_test
// Drives push and clear requests into the framer and checks every header,
// record and trailer against a model of the sample queue kept in the bench.
// It runs a short directed set, then random phases at several thresholds,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------

module sensor_sample_packet_framer_test;

    import sspf_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RECORDS = 25;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic                                  func;
        logic [NUM_VALUES-1:0][VALUE_W-1:0]    channel;
        logic                                  link_ready;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        seq;
        logic [4:0]        records;
        logic [63:0]       front;
        logic [7:0]        tail;
        logic [7:0]        sum;
        logic              closing;
    } frame_t;

    class packet_scoreboard;
        frame_t expected_frames[$];
        logic [NUM_VALUES-1:0][VALUE_W-1:0] store [QUEUE_DEPTH];
        int head_slot;
        int tail_slot;
        int occupancy;
        logic [7:0] packet_number;
        logic [SPP_W-1:0] threshold;
        int mismatches;
        int checked;
        int requests;
        int clears;
        int packets;
        int dropped;

        function new();
            head_slot = 0;
            tail_slot = 0;
            occupancy = 0;
            packet_number = '0;
            threshold = SPP_RESET;
            mismatches = 0;
            checked = 0;
            requests = 0;
            clears = 0;
            packets = 0;
            dropped = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function string show(frame_t f);
            return $sformatf("kind %0d seq %0d records %0d front %h tail %h sum %h final %0b",
                             f.kind, f.seq, f.records, f.front, f.tail, f.sum, f.closing);
        endfunction

        function void note_request(request_t r);
            logic [NUM_VALUES-1:0][VALUE_W-1:0] row;
            logic [7:0] bytes [9];
            logic [7:0] sum;
            frame_t f;
            int rec;
            requests++;
            if (r.func)
            begin
                head_slot = 0;
                tail_slot = 0;
                occupancy = 0;
                clears++;
                return;
            end
            if (occupancy < QUEUE_DEPTH)
            begin
                store[tail_slot] = r.channel;
                tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
                occupancy++;
            end
            else
                dropped++;
            if (!r.link_ready || occupancy < threshold)
                return;
            rec = (occupancy > MAX_RECORDS) ? MAX_RECORDS : occupancy;
            f = '0;
            f.kind = KIND_HEADER;
            f.seq = packet_number;
            f.records = 5'(rec);
            expected_frames.push_back(f);
            sum = packet_number + 8'(rec);
            packet_number++;
            packets++;
            for (int k = 0; k < rec; k++)
            begin
                row = store[head_slot];
                for (int j = 0; j < 3; j++)
                begin
                    bytes[3*j]   = {row[2*j][11:8], row[2*j+1][11:8]};
                    bytes[3*j+1] = row[2*j][7:0];
                    bytes[3*j+2] = row[2*j+1][7:0];
                end
                for (int j = 0; j < 9; j++)
                    sum = sum + bytes[j];
                f = '0;
                f.kind = KIND_RECORD;
                f.front = {bytes[0], bytes[1], bytes[2], bytes[3],
                           bytes[4], bytes[5], bytes[6], bytes[7]};
                f.tail = bytes[8];
                expected_frames.push_back(f);
                head_slot = (head_slot + 1) % QUEUE_DEPTH;
                occupancy--;
            end
            f = '0;
            f.kind = KIND_TRAILER;
            f.sum = sum;
            f.closing = 1'b1;
            expected_frames.push_back(f);
        endfunction

        function void check_result(frame_t got);
            frame_t want;
            checked++;
            if (expected_frames.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result %s", $realtime, show(got));
                mismatches++;
                return;
            end
            want = expected_frames.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("%0t: mismatch\n  expected %s\n  actual   %s",
                             $realtime, show(want), show(got));
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = 1'b0;
    logic [VALUE_W-1:0] value_a = '0;
    logic [VALUE_W-1:0] value_b = '0;
    logic [VALUE_W-1:0] value_c = '0;
    logic [VALUE_W-1:0] value_d = '0;
    logic [VALUE_W-1:0] value_e = '0;
    logic [VALUE_W-1:0] value_f = '0;
    logic               link_ready = 1'b0;
    logic               cfg_write_en = 1'b0;
    logic [SPP_W-1:0]   cfg_write_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [7:0]         sequence_res;
    logic [4:0]         record_count;
    logic [63:0]        packed_front;
    logic [7:0]         packed_tail;
    logic [7:0]         sum_byte;
    logic               final_res;

    packet_scoreboard sb;
    bit quiet = 1'b0;
    int stall_left = 0;
    int thresholds_written = 0;
    int phase_spp [4];
    int phase_items [4];
    int phase_hold [4];
    int phase_link [4];

    sensor_sample_packet_framer #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_RECORDS(MAX_RECORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .value_a(value_a),
        .value_b(value_b),
        .value_c(value_c),
        .value_d(value_d),
        .value_e(value_e),
        .value_f(value_f),
        .link_ready(link_ready),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .sequence_res(sequence_res),
        .record_count(record_count),
        .packed_front(packed_front),
        .packed_tail(packed_tail),
        .sum_byte(sum_byte),
        .final_res(final_res)
    );

    always #10 clk = ~clk;

    // result side stall bursts
    always @(posedge clk)
    begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({kind, sequence_res, record_count, packed_front,
                             packed_tail, sum_byte, final_res});
    end

    function automatic request_t fill_request(logic op, logic [VALUE_W-1:0] even,
                                              logic [VALUE_W-1:0] odd, logic link);
        request_t r;
        r.func = op;
        r.link_ready = link;
        for (int j = 0; j < NUM_VALUES; j++)
            r.channel[j] = (j % 2 == 0) ? even : odd;
        return r;
    endfunction

    function automatic request_t random_request(int link_pct, int clear_pct);
        request_t r;
        r.func = ($urandom_range(0, 99) < clear_pct);
        r.link_ready = ($urandom_range(0, 99) < link_pct);
        for (int j = 0; j < NUM_VALUES; j++)
            r.channel[j] = VALUE_W'($urandom_range(0, 4095));
        return r;
    endfunction

    task automatic send_request(input request_t r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= r.func;
        value_a    <= r.channel[0];
        value_b    <= r.channel[1];
        value_c    <= r.channel[2];
        value_d    <= r.channel[3];
        value_e    <= r.channel[4];
        value_f    <= r.channel[5];
        link_ready <= r.link_ready;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [SPP_W-1:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.threshold = value;
        thresholds_written++;
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold: queue only, below threshold, clear
        send_request(fill_request(1'b0, 12'h000, 12'h000, 1'b0));
        send_request(fill_request(1'b0, 12'hFFF, 12'hFFF, 1'b0));
        send_request(fill_request(1'b0, 12'hAAA, 12'h555, 1'b1));
        send_request(fill_request(1'b1, 12'hFFF, 12'h000, 1'b1));
        send_request(fill_request(1'b0, 12'h5A5, 12'hA5A, 1'b1));

        write_threshold(5'd1);
        send_request(fill_request(1'b0, 12'hFFF, 12'hFFF, 1'b1));
        send_request(random_request(0, 0));
        send_request(fill_request(1'b0, 12'h000, 12'h000, 1'b1));
        send_request(fill_request(1'b1, 12'h123, 12'hDEF, 1'b0));

        // zero threshold acts as one
        write_threshold(5'd0);
        send_request(fill_request(1'b0, 12'hFFF, 12'h000, 1'b1));
        send_request(random_request(100, 0));

        write_threshold(5'd3);
        send_request(fill_request(1'b0, 12'h0F0, 12'hF0F, 1'b1));
        send_request(fill_request(1'b0, 12'h800, 12'h001, 1'b0));
        send_request(fill_request(1'b0, 12'h7FE, 12'h100, 1'b1));

        // threshold above the record limit fills the queue so pushes drop
        phase_spp   = '{25, 31, $urandom_range(2, 24), 2};
        phase_items = '{24, 40, 14, 10};
        phase_hold  = '{0, 34, 0, 0};
        phase_link  = '{50, 70, 60, 60};
        for (int p = 0; p < 4; p++)
        begin
            write_threshold(SPP_W'(phase_spp[p]));
            if (p == 3)
                quiet = 1'b1;
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (i < phase_hold[p])
                    send_request(random_request(0, 0));
                else
                    send_request(random_request(phase_link[p], 6));
            end
        end
        drain();

        $display("covered %0d requests (%0d clears), %0d packets, %0d dropped samplings",
                 sb.requests, sb.clears, sb.packets, sb.dropped);
        $display("checked %0d results over %0d threshold settings",
                 sb.checked, thresholds_written);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
